### design/gru_cell_gate_update_top_assert.svh
// Assertion macros for the GRU gate update block.
`ifndef GRU_CELL_GATE_UPDATE_TOP_ASSERT_SVH
`define GRU_CELL_GATE_UPDATE_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define GCGU_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define GCGU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/gcgu_pkg.sv
// Shared types and number-format constants for the GRU gate update block.
`default_nettype none

package gcgu_pkg;

  // Fixed-point format of every data field
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // Gate value in [0, ONE], unsigned
  localparam int SIG_W = FRAC_BITS + 1;
  // Magnitude fed to the piecewise sigmoid: a data magnitude or twice a tanh argument
  localparam int MAG_W = (DATA_WIDTH > FRAC_BITS + 5) ? DATA_WIDTH : FRAC_BITS + 5;

  // Register stages from the input to the output register
  localparam int NUM_STAGES = 8;

  typedef logic signed [DATA_WIDTH-1:0] gcgu_data_t;

  typedef struct packed {
    gcgu_data_t update_pre;
    gcgu_data_t reset_pre;
    gcgu_data_t cand_input_pre;
    gcgu_data_t cand_recur_pre;
    gcgu_data_t prev_hidden;
    logic       step_valid;
  } gcgu_in_t;

  typedef struct packed {
    gcgu_data_t new_hidden;
    gcgu_data_t sequence_out;
  } gcgu_out_t;

endpackage

`default_nettype wire

### design/gru_cell_gate_update_top.sv
// Top level of the GRU element-wise gate update, linear-before-reset form.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+---------------------------------
//   in_     | in  | in_valid / in_stall   | in_data  (gcgu_in_t, one element)
//   out_    | out | out_valid / out_stall | out_data (gcgu_out_t)
//
// Takes one request per cycle and delivers one result per cycle while out_stall
// is low; the datapath has eight register stages (two gate sigmoids, two
// multiply-and-round pairs, the tanh and the saturating sum).
// Synchronous active-low reset empties every stage; payloads are not reset.
// A stall closes bubbles first: a stage moves whenever it is empty or the stage
// after it moves, so in_stall rises only with every stage full and out stalled.
`default_nettype none

module gru_cell_gate_update_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gcgu_pkg::gcgu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gcgu_pkg::gcgu_out_t out_data
);
  import gcgu_pkg::*;

  // Datapath widths
  localparam int PROD1_W = SIG_W + 1 + DATA_WIDTH;
  localparam int Q_W     = DATA_WIDTH + 1;
  localparam int A_W     = DATA_WIDTH + 2;
  localparam int TW      = (A_W > FRAC_BITS + 5) ? A_W : FRAC_BITS + 5;
  localparam int CLP_W   = FRAC_BITS + 4;
  localparam int HT_W    = FRAC_BITS + 2;
  localparam int D_W     = ((DATA_WIDTH > HT_W) ? DATA_WIDTH : HT_W) + 1;
  localparam int PROD2_W = SIG_W + 1 + D_W;
  localparam int SUM_W   = D_W + 1;

  localparam logic [SIG_W-1:0]         SIG_ONE  = SIG_W'(1) << FRAC_BITS;
  localparam logic [PROD1_W-1:0]       HALF1    = PROD1_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD2_W-1:0]       HALF2    = PROD2_W'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0]            TANH_LIM = TW'(8) << FRAC_BITS;
  localparam logic signed [HT_W-1:0]   HT_ONE   = HT_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0]  SAT_MIN  = ~SAT_MAX;

  // Magnitude of a signed data value; the most negative value maps to 2^(w-1)
  function automatic logic [DATA_WIDTH-1:0] abs_data(input logic signed [DATA_WIDTH-1:0] x);
    logic [DATA_WIDTH-1:0] ux;
    ux = x;
    return x[DATA_WIDTH-1] ? (~ux + 1'b1) : ux;
  endfunction

  // ---------------------------------------------------------------------------
  // Stage valid bits and flow control
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, adv;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !adv[0];

  // ---------------------------------------------------------------------------
  // Stage 0: update and reset gate sigmoids
  // ---------------------------------------------------------------------------
  logic [SIG_W-1:0] sig_upd, sig_rst;
  logic [SIG_W-1:0] s0_z_nxt, s0_r_nxt;
  logic [SIG_W-1:0] s0_z_r, s0_r_r;
  gcgu_data_t       s0_cin_r, s0_crec_r, s0_prev_r;
  logic             s0_step_r;

  gcgu_sig_pos u_sig_upd (
    .mag (MAG_W'(abs_data(in_data.update_pre))),
    .sig (sig_upd)
  );

  gcgu_sig_pos u_sig_rst (
    .mag (MAG_W'(abs_data(in_data.reset_pre))),
    .sig (sig_rst)
  );

  // Mirror the curve for negative arguments
  assign s0_z_nxt = in_data.update_pre[DATA_WIDTH-1] ? SIG_ONE - sig_upd : sig_upd;
  assign s0_r_nxt = in_data.reset_pre[DATA_WIDTH-1] ? SIG_ONE - sig_rst : sig_rst;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_z_r    <= s0_z_nxt;
      s0_r_r    <= s0_r_nxt;
      s0_cin_r  <= in_data.cand_input_pre;
      s0_crec_r <= in_data.cand_recur_pre;
      s0_prev_r <= in_data.prev_hidden;
      s0_step_r <= in_data.step_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: r * recurrent candidate term
  // ---------------------------------------------------------------------------
  logic signed [PROD1_W-1:0] s1_prod_nxt, s1_prod_r;
  logic [SIG_W-1:0]          s1_z_r;
  gcgu_data_t                s1_cin_r, s1_prev_r;
  logic                      s1_step_r;

  assign s1_prod_nxt = PROD1_W'($signed({1'b0, s0_r_r})) * PROD1_W'(s0_crec_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_prod_r <= s1_prod_nxt;
      s1_z_r    <= s0_z_r;
      s1_cin_r  <= s0_cin_r;
      s1_prev_r <= s0_prev_r;
      s1_step_r <= s0_step_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: rescale the product, rounding half away from zero
  // ---------------------------------------------------------------------------
  logic [PROD1_W-1:0]    s2_pu, s2_pmag, s2_prnd;
  logic [Q_W-1:0]        s2_qmag;
  logic signed [Q_W-1:0] s2_q_nxt, s2_q_r;
  logic [SIG_W-1:0]      s2_z_r;
  gcgu_data_t            s2_cin_r, s2_prev_r;
  logic                  s2_step_r;

  always_comb begin
    s2_pu    = s1_prod_r;
    s2_pmag  = s1_prod_r[PROD1_W-1] ? (~s2_pu + 1'b1) : s2_pu;
    s2_prnd  = (s2_pmag + HALF1) >> FRAC_BITS;
    s2_qmag  = s2_prnd[Q_W-1:0];
    s2_q_nxt = s1_prod_r[PROD1_W-1] ? (~s2_qmag + 1'b1) : s2_qmag;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_q_r    <= s2_q_nxt;
      s2_z_r    <= s1_z_r;
      s2_cin_r  <= s1_cin_r;
      s2_prev_r <= s1_prev_r;
      s2_step_r <= s1_step_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: tanh argument, split into sign and clamped magnitude
  // ---------------------------------------------------------------------------
  logic signed [A_W-1:0] s3_a;
  logic [A_W-1:0]        s3_au, s3_amag;
  logic [TW-1:0]         s3_amag_w, s3_clamp;
  logic [CLP_W-1:0]      s3_mag_nxt, s3_mag_r;
  logic                  s3_neg_r;
  logic [SIG_W-1:0]      s3_z_r;
  gcgu_data_t            s3_prev_r;
  logic                  s3_step_r;

  always_comb begin
    s3_a       = A_W'(s2_q_r) + A_W'(s2_cin_r);
    s3_au      = s3_a;
    s3_amag    = s3_a[A_W-1] ? (~s3_au + 1'b1) : s3_au;
    s3_amag_w  = TW'(s3_amag);
    s3_clamp   = (s3_amag_w > TANH_LIM) ? TANH_LIM : s3_amag_w;
    s3_mag_nxt = s3_clamp[CLP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_mag_r  <= s3_mag_nxt;
      s3_neg_r  <= s3_a[A_W-1];
      s3_z_r    <= s2_z_r;
      s3_prev_r <= s2_prev_r;
      s3_step_r <= s2_step_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: tanh(a) = 2 * sigmoid(2|a|) - 1, sign restored
  // ---------------------------------------------------------------------------
  logic [SIG_W-1:0]       sig_tanh, s4_t;
  logic [HT_W-1:0]        s4_tu;
  logic signed [HT_W-1:0] s4_ht_nxt, s4_ht_r;
  logic [SIG_W-1:0]       s4_z_r;
  gcgu_data_t             s4_prev_r;
  logic                   s4_step_r;

  gcgu_sig_pos u_sig_tanh (
    .mag (MAG_W'({s3_mag_r, 1'b0})),
    .sig (sig_tanh)
  );

  always_comb begin
    s4_t      = SIG_W'({sig_tanh, 1'b0} - {1'b0, SIG_ONE});
    s4_tu     = HT_W'(s4_t);
    s4_ht_nxt = s3_neg_r ? (~s4_tu + 1'b1) : s4_tu;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_ht_r   <= s4_ht_nxt;
      s4_z_r    <= s3_z_r;
      s4_prev_r <= s3_prev_r;
      s4_step_r <= s3_step_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: z * (prev - h~)
  // ---------------------------------------------------------------------------
  logic signed [D_W-1:0]     s5_d;
  logic signed [PROD2_W-1:0] s5_prod_nxt, s5_prod_r;
  logic signed [HT_W-1:0]    s5_ht_r;
  gcgu_data_t                s5_prev_r;
  logic                      s5_step_r;

  always_comb begin
    s5_d        = D_W'(s4_prev_r) - D_W'(s4_ht_r);
    s5_prod_nxt = PROD2_W'($signed({1'b0, s4_z_r})) * PROD2_W'(s5_d);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_prod_r <= s5_prod_nxt;
      s5_ht_r   <= s4_ht_r;
      s5_prev_r <= s4_prev_r;
      s5_step_r <= s4_step_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: rescale the second product, rounding half away from zero
  // ---------------------------------------------------------------------------
  logic [PROD2_W-1:0]    s6_pu, s6_pmag, s6_prnd;
  logic [D_W-1:0]        s6_qmag;
  logic signed [D_W-1:0] s6_q_nxt, s6_q_r;
  logic signed [HT_W-1:0] s6_ht_r;
  gcgu_data_t            s6_prev_r;
  logic                  s6_step_r;

  always_comb begin
    s6_pu    = s5_prod_r;
    s6_pmag  = s5_prod_r[PROD2_W-1] ? (~s6_pu + 1'b1) : s6_pu;
    s6_prnd  = (s6_pmag + HALF2) >> FRAC_BITS;
    s6_qmag  = s6_prnd[D_W-1:0];
    s6_q_nxt = s5_prod_r[PROD2_W-1] ? (~s6_qmag + 1'b1) : s6_qmag;
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_q_r    <= s6_q_nxt;
      s6_ht_r   <= s5_ht_r;
      s6_prev_r <= s5_prev_r;
      s6_step_r <= s5_step_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: h~ + z*(prev - h~), saturate; hold prev and zero sequence_out past the sequence end
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] s7_sum;
  gcgu_data_t              s7_sat;
  gcgu_out_t               s7_out_nxt, s7_out_r;
  logic                    s7_step_r;

  always_comb begin
    s7_sum = SUM_W'(s6_q_r) + SUM_W'(s6_ht_r);
    priority if (s7_sum > SAT_MAX) begin
      s7_sat = SAT_MAX[DATA_WIDTH-1:0];
    end else if (s7_sum < SAT_MIN) begin
      s7_sat = SAT_MIN[DATA_WIDTH-1:0];
    end else begin
      s7_sat = s7_sum[DATA_WIDTH-1:0];
    end
    s7_out_nxt.new_hidden   = s6_step_r ? s7_sat : s6_prev_r;
    s7_out_nxt.sequence_out = s6_step_r ? s7_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_out_r  <= s7_out_nxt;
      s7_step_r <= s6_step_r;
    end
  end

  assign out_valid = vld_r[NUM_STAGES-1];
  assign out_data  = s7_out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "gru_cell_gate_update_top_assert.svh"

  `GCGU_ASSERT_IMPL(a_stall_when_full, in_stall, (&vld_r) && out_stall, "stall with a free stage")
  `GCGU_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, vld_r[0], "accepted request not held")
  `GCGU_ASSERT_IMPL(a_tanh_range, vld_r[4], -HT_ONE <= s4_ht_r && s4_ht_r <= HT_ONE, "tanh beyond one")
  `GCGU_ASSERT_IMPL(a_seq_zero, out_valid && !s7_step_r, out_data.sequence_out == '0, "seq out not zero")

endmodule

`default_nettype wire

### design/gcgu_sig_pos.sv
// Piecewise-linear sigmoid on a nonnegative fixed-point magnitude.
`default_nettype none

module gcgu_sig_pos (
  input  logic [gcgu_pkg::MAG_W-1:0] mag,
  output logic [gcgu_pkg::SIG_W-1:0] sig
);
  import gcgu_pkg::*;

  // Segment knees on the magnitude axis
  localparam logic [MAG_W-1:0] KNEE_SAT = MAG_W'(5) << FRAC_BITS;
  localparam logic [MAG_W-1:0] KNEE_HI  = MAG_W'(19) << (FRAC_BITS - 3);
  localparam logic [MAG_W-1:0] KNEE_MID = MAG_W'(1) << FRAC_BITS;

  // Segment offsets on the result axis
  localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(1) << FRAC_BITS;
  localparam logic [SIG_W-1:0] OFF_HI  = SIG_W'(27) << (FRAC_BITS - 5);
  localparam logic [SIG_W-1:0] OFF_MID = SIG_W'(5) << (FRAC_BITS - 3);
  localparam logic [SIG_W-1:0] OFF_LO  = SIG_W'(1) << (FRAC_BITS - 1);

  // Pick the segment; slopes are 1/32, 1/8 and 1/4
  always_comb begin
    priority if (mag >= KNEE_SAT) begin
      sig = SIG_ONE;
    end else if (mag >= KNEE_HI) begin
      sig = SIG_W'(mag >> 5) + OFF_HI;
    end else if (mag >= KNEE_MID) begin
      sig = SIG_W'(mag >> 3) + OFF_MID;
    end else begin
      sig = SIG_W'(mag >> 2) + OFF_LO;
    end
  end

endmodule

`default_nettype wire
